// ===== hdl/dwp_pkg.sv =====
// ----------------------------------------------------------------------------
// dwp_pkg: shared types and constants
// Configuration register layout, register indexes, pipeline depth and the
// control bundle that steers the wheel lanes and the merge stage.
// ----------------------------------------------------------------------------
package dwp_pkg;

  // Register widths fixed by the configuration map
  localparam int GainW   = 24;
  localparam int BandW   = 16;
  localparam int AccW    = 32;
  localparam int DutyW   = 17;
  localparam int CfgIdxW = 3;

  // Pipeline depth: four lane stages plus the output register
  localparam int NStg = 5;

  // Full-scale duty, Q1.16
  localparam logic [DutyW-1:0] DutyFull = 17'h1_0000;

  // Reset values of the band registers
  localparam logic [BandW-1:0] BandNearRst = 16'd5;
  localparam logic [BandW-1:0] BandMidRst  = 16'd10;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_D      = 3'd1,
    REG_GAIN_I_NEAR = 3'd2,
    REG_GAIN_I_MID  = 3'd3,
    REG_GAIN_I_FAR  = 3'd4,
    REG_BAND_NEAR   = 3'd5,
    REG_BAND_MID    = 3'd6
  } cfg_idx_e;

  // Configuration seen by every lane
  typedef struct packed {
    logic [GainW-1:0] gain_p;
    logic [GainW-1:0] gain_d;
    logic [GainW-1:0] gain_i_near;
    logic [GainW-1:0] gain_i_mid;
    logic [GainW-1:0] gain_i_far;
    logic [BandW-1:0] band_near;
    logic [BandW-1:0] band_mid;
  } cfg_t;

  // Per-stage load strobes from the pipeline control
  typedef struct packed {
    logic [NStg-1:0] ld;
  } ctrl_t;

endpackage

// ===== hdl/dwp_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwp_ctrl: pipeline valid tracking and flow control
// Keeps one valid bit per stage and lets each stage fill as soon as the stage
// ahead of it empties, so bubbles collapse and the input keeps flowing while
// a finished result waits at the output, until every stage is occupied.
// ----------------------------------------------------------------------------
module dwp_ctrl
  import dwp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output ctrl_t ctrl_o
);

  logic [NStg-1:0] valid_q, valid_d;
  logic [NStg-1:0] can_load;
  logic [NStg-1:0] depart;
  logic [NStg-1:0] load;

  // Resolve departures from the output backward
  always_comb begin
    depart[NStg-1]   = valid_q[NStg-1] & out_ready_i;
    can_load[NStg-1] = ~valid_q[NStg-1] | depart[NStg-1];
    for (int k = NStg - 2; k >= 0; k--) begin
      depart[k]   = valid_q[k] & can_load[k+1];
      can_load[k] = ~valid_q[k] | depart[k];
    end
    load[0] = in_valid_i & can_load[0];
    for (int k = 1; k < NStg; k++) begin
      load[k] = depart[k-1];
    end
    valid_d = load | (valid_q & ~depart);
  end

  // Hold the per-stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = can_load[0];
  assign out_valid_o = valid_q[NStg-1];
  assign ctrl_o.ld   = load;

  // A stage never loads over an item that stays
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((load & valid_q & ~depart) == '0))
    else $error("pipeline stage overwritten");

  // Only occupied stages hand an item on
  a_depart_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((depart & ~valid_q) == '0))
    else $error("empty stage departed");

  // A stalled result stays at the output
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("stalled result dropped");

endmodule

// ===== hdl/dwp_lane.sv =====
// ----------------------------------------------------------------------------
// dwp_lane: one wheel's incremental PID pipeline
// Error and differences, three gain products, delta sum, saturating
// accumulator update; the unsigned duty is formed from the accumulator.
// ----------------------------------------------------------------------------
module dwp_lane
  import dwp_pkg::*;
#(
  parameter int SPEED_BITS     = 16,
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ctrl_t                        ctrl_i,
  input  cfg_t                         cfg_i,
  input  logic signed [SPEED_BITS-1:0] target_i,
  input  logic signed [SPEED_BITS-1:0] measured_i,
  output logic [DutyW-1:0]             duty_o
);

  localparam int EW  = SPEED_BITS + 1;
  localparam int DW  = SPEED_BITS + 3;
  localparam int CW  = (EW > BandW) ? EW : BandW;
  localparam int PW  = GainW + 1 + DW;
  localparam int SW  = PW + 2;
  localparam int AW  = SW + 1;
  localparam int SHR = (GAIN_FRAC_BITS >= 16) ? GAIN_FRAC_BITS - 16 : 0;
  localparam int SHL = (GAIN_FRAC_BITS < 16) ? 16 - GAIN_FRAC_BITS : 0;

  localparam logic signed [AW-1:0] AccMax = AW'(signed'(32'h7fff_ffff));
  localparam logic signed [AW-1:0] AccMin = AW'(signed'(32'h8000_0000));
  localparam logic signed [32:0]   FullV  = 33'sd1 <<< GAIN_FRAC_BITS;
  localparam logic signed [32:0]   HalfV  = FullV >>> 1;

  // Error history and accumulator
  logic signed [EW-1:0]   e1_q, e2_q;
  logic signed [AccW-1:0] acc_q;

  // Stage registers
  logic signed [EW-1:0]   e_q;
  logic signed [DW-1:0]   dp_q, dd_q;
  logic [GainW-1:0]       ki_q;
  logic signed [PW-1:0]   pp_q, pi_q, pd_q;
  logic signed [SW-1:0]   delta_q;

  // Stage 0: error, magnitude band select, differences
  logic signed [EW-1:0] e_now;
  logic [EW-1:0]        mag;
  logic [GainW-1:0]     ki_sel;
  logic signed [DW-1:0] dp_now, dd_now;

  assign e_now  = EW'(target_i) - EW'(measured_i);
  assign mag    = e_now[EW-1] ? (~e_now + 1'b1) : e_now;
  assign dp_now = DW'(e_now) - DW'(e1_q);
  assign dd_now = DW'(e_now) - (DW'(e1_q) <<< 1) + DW'(e2_q);

  always_comb begin
    if (CW'(mag) < CW'(cfg_i.band_near)) begin
      ki_sel = cfg_i.gain_i_near;
    end else if (CW'(mag) < CW'(cfg_i.band_mid)) begin
      ki_sel = cfg_i.gain_i_mid;
    end else begin
      ki_sel = cfg_i.gain_i_far;
    end
  end

  // Stage 3: accumulate and saturate
  logic signed [AW-1:0]   acc_sum;
  logic signed [AccW-1:0] acc_sat;

  assign acc_sum = AW'(acc_q) + AW'(delta_q);

  always_comb begin
    if (acc_sum > AccMax) begin
      acc_sat = AccW'(AccMax);
    end else if (acc_sum < AccMin) begin
      acc_sat = AccW'(AccMin);
    end else begin
      acc_sat = AccW'(acc_sum);
    end
  end

  // Advance the state on stage 0 and stage 3 loads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q  <= '0;
      e2_q  <= '0;
      acc_q <= '0;
    end else begin
      if (ctrl_i.ld[0]) begin
        e1_q <= e_now;
        e2_q <= e1_q;
      end
      if (ctrl_i.ld[3]) begin
        acc_q <= acc_sat;
      end
    end
  end

  // Datapath stages
  logic signed [GainW:0] gp_s, gd_s, gi_s;

  assign gp_s = {1'b0, cfg_i.gain_p};
  assign gd_s = {1'b0, cfg_i.gain_d};
  assign gi_s = {1'b0, ki_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld[0]) begin
      e_q  <= e_now;
      dp_q <= dp_now;
      dd_q <= dd_now;
      ki_q <= ki_sel;
    end
    if (ctrl_i.ld[1]) begin
      pp_q <= gp_s * dp_q;
      pi_q <= gi_s * e_q;
      pd_q <= gd_s * dd_q;
    end
    if (ctrl_i.ld[2]) begin
      delta_q <= SW'(pp_q) + SW'(pi_q) + SW'(pd_q);
    end
  end

  // Offset by one half, clamp to 0..1 and rescale to Q1.16
  logic signed [32:0] v_off;
  logic [32:0]        v_clamp;
  logic [32:0]        v_shr;

  assign v_off = 33'(acc_q) + HalfV;

  always_comb begin
    if (v_off[32]) begin
      v_clamp = '0;
    end else if (v_off > FullV) begin
      v_clamp = FullV;
    end else begin
      v_clamp = v_off;
    end
  end

  assign v_shr  = v_clamp >> SHR;
  assign duty_o = DutyW'(v_shr << SHL);

  // The history shifts by one on each accepted transaction
  a_hist_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.ld[0] |=> (e2_q == $past(e1_q)) && (e1_q == $past(e_now)))
    else $error("error history not shifted");

endmodule

// ===== hdl/dwp_merge.sv =====
// ----------------------------------------------------------------------------
// dwp_merge: result merge and output register
// Combines the two lane duties into one result, inverting the left wheel,
// and holds it until the transaction completes.
// ----------------------------------------------------------------------------
module dwp_merge
  import dwp_pkg::*;
(
  input  logic             clk_i,
  input  ctrl_t            ctrl_i,
  input  logic [DutyW-1:0] duty_left_i,
  input  logic [DutyW-1:0] duty_right_i,
  output logic [DutyW-1:0] duty_left_o,
  output logic [DutyW-1:0] duty_right_o
);

  logic [DutyW-1:0] duty_left_q, duty_right_q;

  // Load the result; invert the left wheel
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld[NStg-1]) begin
      duty_left_q  <= DutyFull - duty_left_i;
      duty_right_q <= duty_right_i;
    end
  end

  assign duty_left_o  = duty_left_q;
  assign duty_right_o = duty_right_q;

endmodule

// ===== hdl/dual_wheel_incremental_pid.sv =====
// ----------------------------------------------------------------------------
// dual_wheel_incremental_pid: two-wheel incremental PID speed controller
// Takes a target and measured speed per wheel and returns a Q1.16 duty per
// wheel, the left one inverted, from a gain-scheduled velocity-form PID.
// ----------------------------------------------------------------------------
// Each transaction passes through a five-stage pipeline (error and band
// select, gain products, delta sum, saturating accumulator update, output
// register), and a new input is taken every cycle while the output is not
// stalled; the two wheels run in parallel lanes. Throughput is one
// transaction per cycle when the output is not stalled, as each lane
// updates its accumulator once per item. Write configuration only while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module dual_wheel_incremental_pid
  import dwp_pkg::*;
#(
  parameter int SPEED_BITS     = 16,
  parameter int GAIN_FRAC_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CfgIdxW-1:0]           cfg_idx_i,
  input  logic [GainW-1:0]             cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SPEED_BITS-1:0] target_left_i,
  input  logic signed [SPEED_BITS-1:0] target_right_i,
  input  logic signed [SPEED_BITS-1:0] measured_left_i,
  input  logic signed [SPEED_BITS-1:0] measured_right_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [DutyW-1:0]             duty_left_o,
  output logic [DutyW-1:0]             duty_right_o
);

  cfg_t             cfg_q;
  ctrl_t            ctrl;
  logic [DutyW-1:0] lane_duty_left, lane_duty_right;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p      <= '0;
      cfg_q.gain_d      <= '0;
      cfg_q.gain_i_near <= '0;
      cfg_q.gain_i_mid  <= '0;
      cfg_q.gain_i_far  <= '0;
      cfg_q.band_near   <= BandNearRst;
      cfg_q.band_mid    <= BandMidRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN_P:      cfg_q.gain_p      <= cfg_wdata_i;
        REG_GAIN_D:      cfg_q.gain_d      <= cfg_wdata_i;
        REG_GAIN_I_NEAR: cfg_q.gain_i_near <= cfg_wdata_i;
        REG_GAIN_I_MID:  cfg_q.gain_i_mid  <= cfg_wdata_i;
        REG_GAIN_I_FAR:  cfg_q.gain_i_far  <= cfg_wdata_i;
        REG_BAND_NEAR:   cfg_q.band_near   <= cfg_wdata_i[BandW-1:0];
        REG_BAND_MID:    cfg_q.band_mid    <= cfg_wdata_i[BandW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Flow control
  dwp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  // Left wheel lane
  dwp_lane #(
    .SPEED_BITS     (SPEED_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_lane_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cfg_i      (cfg_q),
    .target_i   (target_left_i),
    .measured_i (measured_left_i),
    .duty_o     (lane_duty_left)
  );

  // Right wheel lane
  dwp_lane #(
    .SPEED_BITS     (SPEED_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_lane_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cfg_i      (cfg_q),
    .target_i   (target_right_i),
    .measured_i (measured_right_i),
    .duty_o     (lane_duty_right)
  );

  // Merge and output register
  dwp_merge u_merge (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .duty_left_i  (lane_duty_left),
    .duty_right_i (lane_duty_right),
    .duty_left_o  (duty_left_o),
    .duty_right_o (duty_right_o)
  );

endmodule
